[design/tkm_pkg.sv]
// Package for the top-k max-abs score selector: payload structs, sizes and
// the saturating absolute-value helper. No dependencies.
package tkm_pkg;

   localparam int NumScores   = 6;
   localparam int ScoreFields = 6;
   localparam int NumUsed     = (NumScores < ScoreFields) ? NumScores : ScoreFields;
   localparam int MaxKept     = 16;
   localparam int CountW      = $clog2(MaxKept + 1);
   localparam int IdxW        = (MaxKept > 1) ? $clog2(MaxKept) : 1;
   localparam int KeyW        = 48;
   localparam int ScoreW      = 32;
   localparam int RankW       = 31;
   localparam int TopCountW   = 5;
   localparam int TopCountRst = 16;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [KeyW-1:0]          entry_key;
      logic signed [ScoreW-1:0] score_0;
      logic signed [ScoreW-1:0] score_1;
      logic signed [ScoreW-1:0] score_2;
      logic signed [ScoreW-1:0] score_3;
      logic signed [ScoreW-1:0] score_4;
      logic signed [ScoreW-1:0] score_5;
      logic                     final_entry;
   } req_type;

   typedef struct packed {
      logic [15:0] bucket_id;
      logic [7:0]  street;
      logic [15:0] pot_amount;
      logic [7:0]  action_seq;
      logic        last_result;
   } rsp_type;

   // classified entry handed from front to back
   typedef struct packed {
      logic [KeyW-1:0]  key;
      logic [RankW-1:0] rank;
      logic             final_entry;
   } item_type;

   function automatic logic [RankW-1:0] abs_sat(input logic [ScoreW-1:0] s);
      logic [ScoreW-1:0] neg;
      neg = ~s + 1'b1;
      if (!s[ScoreW-1]) begin
         return s[RankW-1:0];
      end
      // most negative value has no positive twin
      if (neg[ScoreW-1]) begin
         return {RankW{1'b1}};
      end
      return neg[RankW-1:0];
   endfunction

endpackage

[design/tkm_front.sv]
// Front end of the top-k selector: accepts request beats, registers the
// absolute scores and forms the rank. Depends on tkm_pkg.
module tkm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tkm_pkg::req_type req_data,
   output logic             item_valid,
   input  logic             item_ready,
   output tkm_pkg::item_type item_data
);
   import tkm_pkg::*;

   logic [ScoreW-1:0] scores [ScoreFields];
   logic              stage_valid_ff, stage_valid_in;
   logic [RankW-1:0]  abs_ff [NumUsed];
   logic [KeyW-1:0]   key_ff;
   logic              final_ff;
   logic              accept;
   logic [RankW-1:0]  rank_max;

   assign scores[0] = req_data.score_0;
   assign scores[1] = req_data.score_1;
   assign scores[2] = req_data.score_2;
   assign scores[3] = req_data.score_3;
   assign scores[4] = req_data.score_4;
   assign scores[5] = req_data.score_5;

   assign req_stall = stage_valid_ff && !item_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (item_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NumUsed; i++) begin
            abs_ff[i] <= abs_sat(scores[i]);
         end
         key_ff   <= req_data.entry_key;
         final_ff <= req_data.final_entry;
      end
   end

   always_comb begin
      rank_max = '0;
      for (int i = 0; i < NumUsed; i++) begin
         if (abs_ff[i] > rank_max) begin
            rank_max = abs_ff[i];
         end
      end
   end

   assign item_valid            = stage_valid_ff;
   assign item_data.key         = key_ff;
   assign item_data.rank        = rank_max;
   assign item_data.final_entry = final_ff;

endmodule

[design/tkm_queue.sv]
// Two-entry queue between front and back of the top-k selector.
// Depends on tkm_pkg.
module tkm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tkm_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tkm_pkg::item_type pop_data
);
   import tkm_pkg::*;

   item_type             mem [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0] count_ff;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[design/tkm_back.sv]
// Back end of the top-k selector: sorted cell chain with parallel compares,
// insert updating all cells at once, and the report sequencer with its
// output register. Depends on tkm_pkg.
module tkm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tkm_pkg::TopCountW-1:0]   top_count,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  tkm_pkg::item_type               item_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tkm_pkg::rsp_type                rsp_data
);
   import tkm_pkg::*;

   typedef enum logic [1:0] {
      StIdle = 2'b01,
      StEmit = 2'b10
   } back_state_type;

   back_state_type    state_ff;
   logic [KeyW-1:0]   key_ff  [MaxKept];
   logic [RankW-1:0]  rank_ff [MaxKept];
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] total_ff;
   logic [CountW-1:0] idx_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [CountW-1:0] cap, cnt_c, new_cnt;
   logic [MaxKept-1:0] ge, below;
   logic              ins_ok, pop, load, last_beat;
   logic [KeyW-1:0]   emit_key;
   logic [CountW-1:0] idx_next;

   always_comb begin
      cap = (32'(top_count) > MaxKept) ? CountW'(MaxKept) : CountW'(top_count);
      cnt_c = (count_ff > cap) ? cap : count_ff;
      for (int i = 0; i < MaxKept; i++) begin
         ge[i]    = (CountW'(i) < cnt_c) && (rank_ff[i] >= item_data.rank);
         below[i] = (CountW'(i) < cap);
      end
      // some slot under the limit loses to the new entry
      ins_ok  = |(~ge & below);
      new_cnt = cnt_c;
      if (ins_ok && (cnt_c < cap)) begin
         new_cnt = cnt_c + 1'b1;
      end
   end

   assign item_ready = (state_ff == StIdle);
   assign pop        = item_valid && item_ready;
   assign load       = !rsp_valid_ff || !rsp_stall;
   assign emit_key   = key_ff[idx_ff[IdxW-1:0]];
   assign idx_next   = idx_ff + 1'b1;
   assign last_beat  = (idx_next == total_ff);

   // cells: those ahead of the insert point hold, the rest shift down
   always_ff @(posedge clock) begin
      if (pop && ins_ok) begin
         for (int i = 0; i < MaxKept; i++) begin
            if (!ge[i]) begin
               if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                  key_ff[i]  <= item_data.key;
                  rank_ff[i] <= item_data.rank;
               end else begin
                  key_ff[i]  <= key_ff[(i == 0) ? 0 : i - 1];
                  rank_ff[i] <= rank_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            StIdle: begin
               if (pop) begin
                  count_ff <= item_data.final_entry ? '0 : new_cnt;
                  if (item_data.final_entry && (new_cnt != '0)) begin
                     state_ff <= StEmit;
                     total_ff <= new_cnt;
                     idx_ff   <= '0;
                  end
               end
               if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            StEmit: begin
               if (load) begin
                  rsp_valid_ff <= 1'b1;
                  idx_ff       <= idx_next;
                  if (last_beat) begin
                     state_ff <= StIdle;
                  end
               end
            end
            default: begin
               state_ff <= StIdle;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == StEmit) && load) begin
         rsp_data_ff.bucket_id   <= emit_key[15:0];
         rsp_data_ff.street      <= emit_key[23:16];
         rsp_data_ff.pot_amount  <= emit_key[39:24];
         rsp_data_ff.action_seq  <= emit_key[47:40];
         rsp_data_ff.last_result <= last_beat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/top_k_max_abs_score_select.sv]
// Top-k selector by largest absolute score. A request beat passes the front end's
// score register and the queue before the back end; non-final entries sustain one
// per cycle. A final entry's first result beat comes out after the back end's StEmit
// state and its output register, then one result beat per cycle while rsp_stall is low;
// the back end takes no entries while it reports. Synchronous active-high reset empties
// the list and sets top_count to 16. Depends on tkm_pkg, tkm_front, tkm_queue, tkm_back.
module top_k_max_abs_score_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tkm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tkm_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tkm_pkg::TopCountW-1:0] csr_data
);
   import tkm_pkg::*;

   logic [TopCountW-1:0] top_count_ff;
   logic                 f_valid, f_ready, b_valid, b_ready;
   item_type             f_data, b_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TopCountW'(TopCountRst);
      end else if (csr_valid) begin
         top_count_ff <= csr_data;
      end
   end

   tkm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item_data  (f_data)
   );

   tkm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   tkm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .top_count  (top_count_ff),
      .item_valid (b_valid),
      .item_ready (b_ready),
      .item_data  (b_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/sv/top_k_max_abs_score_select_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for top_k_max_abs_score_select: directed and random entry sets,
// predicted against a behavioral copy of the ranked list. Depends on tkm_pkg and the RTL.
module top_k_max_abs_score_select_test;
   import tkm_pkg::*;

   localparam int RandomEntries = 230;
   localparam int SettleCycles  = 16;
   localparam int IdleLimit     = 3000;
   localparam int PressureHold  = 200;
   localparam int ReportLimit   = 10;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TopCountW-1:0] csr_data  = '0;

   req_type pending_entries[$];
   rsp_type expected_reports[$];
   int      entries_queued = 0;
   int      entries_taken  = 0;
   int      mismatches     = 0;
   int      idle_cycles    = 0;
   int      hold_requests  = 0;
   int      holds_served   = 0;
   int      hold_left      = 0;
   int      calm_left      = 0;
   int      gap_left       = 0;
   int      burst_left     = 0;

   // predicted ranked list, highest rank first
   logic [KeyW-1:0]  list_key  [MaxKept];
   logic [RankW-1:0] list_rank [MaxKept];
   int               list_len      = 0;
   int               top_count_now = TopCountRst;

   top_k_max_abs_score_select dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [RankW-1:0] magnitude(input logic [ScoreW-1:0] s);
      logic [ScoreW-1:0] m;
      m = 32'd0 - s;
      if (!s[ScoreW-1]) begin
         return s[RankW-1:0];
      end
      // -2^31 clips to the largest positive rank
      if (m[ScoreW-1]) begin
         return {RankW{1'b1}};
      end
      return m[RankW-1:0];
   endfunction

   function automatic logic [RankW-1:0] entry_rank(input req_type e);
      logic [ScoreW-1:0] s [6];
      logic [RankW-1:0]  best;
      logic [RankW-1:0]  a;
      s[0] = e.score_0;
      s[1] = e.score_1;
      s[2] = e.score_2;
      s[3] = e.score_3;
      s[4] = e.score_4;
      s[5] = e.score_5;
      best = '0;
      for (int i = 0; i < 6; i++) begin
         a = magnitude(s[i]);
         if (a > best) begin
            best = a;
         end
      end
      return best;
   endfunction

   // insert one accepted entry; on a final entry, queue the report and empty the list
   function automatic void predict_entry(input req_type e);
      logic [RankW-1:0] r;
      rsp_type          beat;
      int               cap;
      int               pos;
      int               n;
      r   = entry_rank(e);
      cap = (top_count_now > MaxKept) ? MaxKept : top_count_now;
      if (list_len > cap) begin
         list_len = cap;
      end
      if (cap != 0) begin
         pos = 0;
         while (pos < list_len && list_rank[pos] >= r) begin
            pos++;
         end
         if (pos < cap) begin
            if (list_len < cap) begin
               list_len++;
            end
            for (int i = list_len - 1; i > pos; i--) begin
               list_key[i]  = list_key[i-1];
               list_rank[i] = list_rank[i-1];
            end
            list_key[pos]  = e.entry_key;
            list_rank[pos] = r;
         end
      end
      if (e.final_entry) begin
         n = (list_len < cap) ? list_len : cap;
         for (int i = 0; i < n; i++) begin
            beat.bucket_id   = list_key[i][15:0];
            beat.street      = list_key[i][23:16];
            beat.pot_amount  = list_key[i][39:24];
            beat.action_seq  = list_key[i][47:40];
            beat.last_result = (i == n - 1);
            expected_reports.insert(expected_reports.size(), beat);
         end
         list_len = 0;
      end
   endfunction

   function automatic void queue_entry(input logic [KeyW-1:0] key,
                                       input logic [ScoreW-1:0] s0, input logic [ScoreW-1:0] s1,
                                       input logic [ScoreW-1:0] s2, input logic [ScoreW-1:0] s3,
                                       input logic [ScoreW-1:0] s4, input logic [ScoreW-1:0] s5,
                                       input logic fin);
      req_type e;
      e.entry_key   = key;
      e.score_0     = s0;
      e.score_1     = s1;
      e.score_2     = s2;
      e.score_3     = s3;
      e.score_4     = s4;
      e.score_5     = s5;
      e.final_entry = fin;
      pending_entries.insert(pending_entries.size(), e);
      entries_queued++;
   endfunction

   function automatic logic [ScoreW-1:0] random_score(input int mode);
      logic [ScoreW-1:0] v;
      case (mode)
         0: begin
            v = $urandom;
         end
         1: begin
            // small Q16.16 integers, so ranks tie often
            v = ($urandom_range(0, 8) - 4) * 32'h0001_0000;
         end
         default: begin
            case ($urandom_range(0, 6))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h8000_0001;
               3: v = 32'hFFFF_FFFF;
               4: v = 32'h0000_0000;
               5: v = 32'h0000_0001;
               default: v = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic void queue_random_entry(input int mode, input logic fin);
      logic [63:0] w;
      w = {$urandom, $urandom};
      queue_entry(w[KeyW-1:0], random_score(mode), random_score(mode), random_score(mode),
                  random_score(mode), random_score(mode), random_score(mode), fin);
   endfunction

   function automatic int random_limit();
      if ($urandom_range(0, 9) < 3) begin
         case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return MaxKept;
            default: return 31;
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         return $urandom_range(0, 31);
      end
      return $urandom_range(1, MaxKept);
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst_left = $urandom_range(20, 50);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // block has taken every entry, delivered every result, and had time to settle
   task automatic wait_quiet();
      while (entries_taken != entries_queued || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_top_count(input int value);
      wait_quiet();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[TopCountW-1:0];
      do @(posedge clock); while (!csr_ready);
      top_count_now = value;
      csr_valid <= 1'b0;
   endtask

   // driver: offers queued entries with random gaps, predicts on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_entry(req_data);
            entries_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_entries.size() != 0) begin
               req_data  <= pending_entries.pop_front();
               req_valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure; a requested long hold lets the block fill up
   always @(posedge clock) begin : receiver
      logic stall_next;
      int   r;
      stall_next = 1'b0;
      if (reset) begin
         stall_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left  = PressureHold - 1;
         stall_next = 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            calm_left = $urandom_range(20, 60);
         end else if (r < 5) begin
            hold_left  = $urandom_range(15, 40);
            stall_next = 1'b1;
         end else if (r < 30) begin
            hold_left  = $urandom_range(0, 3);
            stall_next = 1'b1;
         end
      end
      rsp_stall <= stall_next;
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("result beat with nothing pending: %p", rsp_data);
            end
         end else begin
            want = expected_reports.pop_front();
            if (want.bucket_id !== rsp_data.bucket_id || want.street !== rsp_data.street ||
                want.pot_amount !== rsp_data.pot_amount ||
                want.action_seq !== rsp_data.action_seq ||
                want.last_result !== rsp_data.last_result) begin
               mismatches++;
               if (mismatches <= ReportLimit) begin
                  $display("mismatch: expected bucket %h street %h pot %h seq %h last %b",
                           want.bucket_id, want.street, want.pot_amount, want.action_seq,
                           want.last_result);
                  $display("          actual   bucket %h street %h pot %h seq %h last %b",
                           rsp_data.bucket_id, rsp_data.street, rsp_data.pot_amount,
                           rsp_data.action_seq, rsp_data.last_result);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int  directed_count;
      int  len;
      int  mode;
      bit  unfinished;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset limit of 16: zero key and scores, then saturation and rank ties
      queue_entry(48'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      queue_entry(48'hFFFF_FFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0102_0304_0506, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
      queue_entry(48'hAA55_AA55_AA55, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h5AA5_5AA5_5AA5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 1'b0);
      queue_entry(48'h8000_0000_0001, 32'h8000_0001, 32'hFFFF_0000, 32'h7FFF_0000,
                  32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b1);

      // nothing kept, final reports nothing
      write_top_count(0);
      queue_entry(48'h1234_5678_9ABC, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'hCBA9_8765_4321, 32'h0, 32'h0007_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);

      write_top_count(31);
      queue_entry(48'h0F0F_F0F0_0F0F, 32'h0, 32'h0, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0, 1'b1);

      // full list: equal-to-lowest entry does not enter
      write_top_count(3);
      queue_entry(48'h0000_0000_0005, 32'h5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0000_0009, 32'h9, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0000_0107, 32'hFFFF_FFF9, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0000_0209, 32'h0, 32'h9, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0000_0302, 32'h2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0000_0407, 32'h0, 32'h0, 32'h7, 32'h0, 32'h0, 32'h0, 1'b1);

      // limit lowered in the middle of a set
      write_top_count(8);
      queue_entry(48'h0000_0001_0028, 32'd40, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0002_001E, 32'd30, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0003_0014, 32'd20, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0004_000A, 32'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      write_top_count(2);
      queue_entry(48'h0000_0005_0019, 32'd25, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);

      // limit raised mid-set: dropped entries stay dropped
      write_top_count(1);
      queue_entry(48'h0000_0006_0003, 32'd3, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_entry(48'h0000_0007_0008, 32'd8, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      write_top_count(4);
      queue_entry(48'h0000_0008_0005, 32'd5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      directed_count = entries_queued;

      // long receiver hold while two full sets keep the input busy
      write_top_count(MaxKept);
      @(negedge clock);
      hold_requests++;
      for (int k = 0; k < 20; k++) queue_random_entry(0, k == 19);
      for (int k = 0; k < 20; k++) queue_random_entry(2, k == 19);

      unfinished = 1'b0;
      while (entries_queued < directed_count + RandomEntries) begin
         if (unfinished || $urandom_range(0, 2) == 0) begin
            write_top_count(random_limit());
         end
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         unfinished = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < len; k++) begin
            queue_random_entry(mode, (k == len - 1) && !unfinished);
         end
      end
      queue_random_entry(0, 1'b1);

      wait_quiet();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[top_k_max_abs_score_select.f]
design/tkm_pkg.sv
design/tkm_front.sv
design/tkm_queue.sv
design/tkm_back.sv
design/top_k_max_abs_score_select.sv
tb/sv/top_k_max_abs_score_select_test.sv
